>>> design/wzs_pkg.sv
// Package for the window z-order stack: operation codes, the placement
// record, the control bundle sent to every cell and the controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wzs_pkg;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_RAISE = 3'd2;
  localparam logic [2:0] OP_PLACE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_TOP   = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [11:0] width;
    logic [11:0] height;
  } placement_t;

  typedef struct packed {
    logic        push_en;
    logic        shift_en;
    logic        raise_en;
    logic        place_en;
    logic [15:0] new_id;
    placement_t  new_pl;
    placement_t  keep_pl;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

endpackage

`default_nettype wire

>>> design/window_z_order_stack_core.sv
// Top level of the window z-order stack: controller, output register and
// the row of slot cells. Depends on wzs_pkg and wzs_cell.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to DEPTH windows ordered from bottom to top and answers push,
// erase, raise, place, query and top requests with one result beat each.
// When a request is accepted every cell registers whether its id matches
// the request; in the commit state the match ripples through the row of
// cells and the update and the result are committed together.
// The commit waits while a previous result is still held on the output, and
// the input is stalled while the controller is in the commit state.
module window_z_order_stack_core import wzs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] pane_id,
  input  wire logic [1:0]  place_kind,
  input  wire logic [11:0] place_col,
  input  wire logic [11:0] place_row,
  input  wire logic [11:0] place_width,
  input  wire logic [11:0] place_height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic             found,
  output logic [3:0]       z_index,
  output logic [15:0]      top_pane,
  output logic [1:0]       got_kind,
  output logic [11:0]      got_col,
  output logic [11:0]      got_row,
  output logic [11:0]      got_width,
  output logic [11:0]      got_height,
  output logic [4:0]       live_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t      state;
  state_t      state_next;
  logic        capture;
  logic        go;
  logic [2:0]  op;
  logic [15:0] id;
  placement_t  pl;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  cell_ctl_t   ctl;
  logic        hit;
  logic        nonempty;

  logic [DEPTH:0]   seen_c;
  placement_t       hit_pl_c [DEPTH+1];
  logic [IW-1:0]    hit_pos_c [DEPTH+1];
  logic [15:0]      top_c [DEPTH+1];
  logic [15:0]      id_c [DEPTH+1];
  placement_t       pl_c [DEPTH+1];

  logic [IW+3:0]    pos_ext;
  logic [CW+4:0]    count_ext;

  assign seen_c[0]    = 1'b0;
  assign hit_pl_c[0]  = '0;
  assign hit_pos_c[0] = '0;
  assign top_c[0]     = '0;
  assign id_c[DEPTH]  = '0;
  assign pl_c[DEPTH]  = '0;

  assign capture  = in_valid && !in_stall;
  assign hit      = seen_c[DEPTH];
  assign nonempty = (count != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (capture) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    go       = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_COMMIT: go = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.new_id   = id;
    ctl.new_pl   = pl;
    ctl.keep_pl  = hit_pl_c[DEPTH];
    ctl.push_en  = go && (op == OP_PUSH) && (id != 16'd0) && !hit &&
                   (count != CW'(DEPTH));
    ctl.shift_en = go && ((op == OP_ERASE) || (op == OP_RAISE)) && hit;
    ctl.raise_en = go && (op == OP_RAISE) && hit;
    ctl.place_en = go && (op == OP_PLACE) && hit;
  end

  always_comb begin
    count_next = count;
    if (ctl.push_en) begin
      count_next = count + CW'(1);
    end else if (ctl.shift_en && !ctl.raise_en) begin
      count_next = count - CW'(1);
    end
  end

  assign pos_ext   = {4'd0, hit_pos_c[DEPTH]};
  assign count_ext = {5'd0, count_next};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    wzs_cell #(
      .INDEX (i),
      .CW    (CW),
      .IW    (IW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .capture     (capture),
      .pane_id     (pane_id),
      .ctl         (ctl),
      .count       (count),
      .nb_id       (id_c[i+1]),
      .nb_pl       (pl_c[i+1]),
      .seen_in     (seen_c[i]),
      .hit_pl_in   (hit_pl_c[i]),
      .hit_pos_in  (hit_pos_c[i]),
      .top_in      (top_c[i]),
      .seen_out    (seen_c[i+1]),
      .hit_pl_out  (hit_pl_c[i+1]),
      .hit_pos_out (hit_pos_c[i+1]),
      .top_out     (top_c[i+1]),
      .id          (id_c[i]),
      .pl          (pl_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op <= operation;
      id <= pane_id;
      pl <= '{kind: place_kind, col: place_col, row: place_row,
              width: place_width, height: place_height};
    end
    if (go) begin
      accepted   <= ctl.push_en || ctl.shift_en || ctl.place_en;
      found      <= ((op == OP_QUERY) && hit) || ((op == OP_TOP) && nonempty);
      z_index    <= ((op == OP_QUERY) && hit) ? pos_ext[3:0] : 4'd0;
      top_pane   <= ((op == OP_TOP) && nonempty) ? top_c[DEPTH] : 16'd0;
      got_kind   <= ((op == OP_QUERY) && hit) ? hit_pl_c[DEPTH].kind : 2'd0;
      got_col    <= ((op == OP_QUERY) && hit) ? hit_pl_c[DEPTH].col : 12'd0;
      got_row    <= ((op == OP_QUERY) && hit) ? hit_pl_c[DEPTH].row : 12'd0;
      got_width  <= ((op == OP_QUERY) && hit) ? hit_pl_c[DEPTH].width : 12'd0;
      got_height <= ((op == OP_QUERY) && hit) ? hit_pl_c[DEPTH].height : 12'd0;
      live_count <= count_ext[4:0];
    end
  end

endmodule

`default_nettype wire

>>> design/wzs_cell.sv
// One slot of the window z-order stack: holds an id and a placement, and
// passes the match, the matched placement, its position and the top id on.
// Depends on wzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wzs_cell import wzs_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 5,
  parameter int IW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          capture,
  input  wire logic [15:0]   pane_id,
  input  wire cell_ctl_t     ctl,
  input  wire logic [CW-1:0] count,
  input  wire logic [15:0]   nb_id,
  input  wire placement_t    nb_pl,
  input  wire logic          seen_in,
  input  wire placement_t    hit_pl_in,
  input  wire logic [IW-1:0] hit_pos_in,
  input  wire logic [15:0]   top_in,
  output logic               seen_out,
  output placement_t         hit_pl_out,
  output logic [IW-1:0]      hit_pos_out,
  output logic [15:0]        top_out,
  output logic [15:0]        id,
  output placement_t         pl
);

  logic       match;
  logic       is_tail;
  logic       is_last;
  logic [15:0] id_next;
  placement_t  pl_next;

  assign is_tail     = (count == CW'(INDEX));
  assign is_last     = (count == CW'(INDEX + 1));
  assign seen_out    = seen_in | match;
  assign hit_pl_out  = match ? pl : hit_pl_in;
  assign hit_pos_out = match ? IW'(INDEX) : hit_pos_in;
  assign top_out     = is_last ? id : top_in;

  always_comb begin
    id_next = id;
    pl_next = pl;
    if (ctl.push_en && is_tail) begin
      id_next = ctl.new_id;
      pl_next = ctl.new_pl;
    end else if (ctl.shift_en && seen_out) begin
      if (ctl.raise_en && is_last) begin
        id_next = ctl.new_id;
        pl_next = ctl.keep_pl;
      end else begin
        id_next = nb_id;
        pl_next = nb_pl;
      end
    end else if (ctl.place_en && match) begin
      pl_next = ctl.new_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id    <= '0;
      pl    <= '0;
      match <= 1'b0;
    end else begin
      id <= id_next;
      pl <= pl_next;
      if (capture) begin
        match <= (pane_id != 16'd0) && (pane_id == id);
      end
    end
  end

endmodule

`default_nettype wire
